[src/pkd_pkg.sv]
`default_nettype none

package pkd_pkg;

  typedef enum logic {
    KIND_KITE = 1'b0,
    KIND_DART = 1'b1
  } pkd_kind_e;

  typedef enum logic [1:0] {
    TIP_PARENT = 2'd0,
    TIP_LEFT   = 2'd1,
    TIP_RIGHT  = 2'd2
  } pkd_tip_e;

  localparam int unsigned SideW   = 24;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned AngW    = 5;
  localparam int unsigned AngMod  = 20;
  localparam int unsigned QuarterTurn = 15;
  localparam int unsigned TipTurnLeft  = 18;
  localparam int unsigned TipTurnRight = 2;
  localparam int unsigned KiteKids = 6;
  localparam int unsigned DartKids = 5;
  localparam int unsigned KidW     = 3;
  localparam int unsigned MagW     = 31;
  localparam int unsigned ProdW    = SideW + MagW;
  localparam int unsigned OffW     = 27;
  localparam int unsigned TipW     = 34;
  localparam int unsigned CtrW     = 35;

  localparam logic [31:0] InvPhiQ32 = 32'h9E3779B9;
  localparam logic [29:0] Cos36Q30  = 30'd868675383;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } pkd_trig_t;

  typedef struct packed {
    pkd_kind_e       kind;
    pkd_tip_e        tip;
    logic [AngW-1:0] turn;
  } pkd_kid_t;

  typedef struct packed {
    logic                     valid;
    pkd_kind_e                kind;
    pkd_tip_e                 tip;
    logic                     last;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SideW-1:0]         side;
    logic [AngW-1:0]          angle;
    logic [AngW-1:0]          cangle;
  } pkd_child_t;

  function automatic logic [AngW-1:0] add_mod20(input logic [AngW-1:0] a,
                                                 input logic [AngW-1:0] b);
    logic [AngW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AngW+1)'(AngMod)) begin
      s = s - (AngW+1)'(AngMod);
    end
    return s[AngW-1:0];
  endfunction

  // cos(k * 18 deg) in Q2.30 as sign and magnitude.
  function automatic pkd_trig_t cos_lookup(input logic [AngW-1:0] k);
    pkd_trig_t t;
    t.neg = 1'b0;
    t.mag = '0;
    unique case (k)
      5'd0:  begin t.mag = 31'd1073741824; end
      5'd1:  begin t.mag = 31'd1021189159; end
      5'd2:  begin t.mag = 31'd868675383;  end
      5'd3:  begin t.mag = 31'd631129609;  end
      5'd4:  begin t.mag = 31'd331804471;  end
      5'd5:  begin t.mag = 31'd0;          end
      5'd6:  begin t.mag = 31'd331804471;  t.neg = 1'b1; end
      5'd7:  begin t.mag = 31'd631129609;  t.neg = 1'b1; end
      5'd8:  begin t.mag = 31'd868675383;  t.neg = 1'b1; end
      5'd9:  begin t.mag = 31'd1021189159; t.neg = 1'b1; end
      5'd10: begin t.mag = 31'd1073741824; t.neg = 1'b1; end
      5'd11: begin t.mag = 31'd1021189159; t.neg = 1'b1; end
      5'd12: begin t.mag = 31'd868675383;  t.neg = 1'b1; end
      5'd13: begin t.mag = 31'd631129609;  t.neg = 1'b1; end
      5'd14: begin t.mag = 31'd331804471;  t.neg = 1'b1; end
      5'd15: begin t.mag = 31'd0;          end
      5'd16: begin t.mag = 31'd331804471;  end
      5'd17: begin t.mag = 31'd631129609;  end
      5'd18: begin t.mag = 31'd868675383;  end
      5'd19: begin t.mag = 31'd1021189159; end
      default: begin t.mag = '0; end
    endcase
    return t;
  endfunction

  function automatic pkd_kid_t kid_lookup(input pkd_kind_e parent,
                                          input logic [KidW-1:0] k);
    pkd_kid_t c;
    c = '{kind: KIND_KITE, tip: TIP_PARENT, turn: '0};
    if (parent == KIND_KITE) begin
      unique case (k)
        3'd0:    c = '{kind: KIND_DART, tip: TIP_PARENT, turn: 5'd18};
        3'd1:    c = '{kind: KIND_DART, tip: TIP_PARENT, turn: 5'd2};
        3'd2:    c = '{kind: KIND_KITE, tip: TIP_LEFT,   turn: 5'd6};
        3'd3:    c = '{kind: KIND_KITE, tip: TIP_LEFT,   turn: 5'd10};
        3'd4:    c = '{kind: KIND_KITE, tip: TIP_RIGHT,  turn: 5'd14};
        3'd5:    c = '{kind: KIND_KITE, tip: TIP_RIGHT,  turn: 5'd10};
        default: c = '{kind: KIND_KITE, tip: TIP_PARENT, turn: 5'd0};
      endcase
    end else begin
      unique case (k)
        3'd0:    c = '{kind: KIND_KITE, tip: TIP_PARENT, turn: 5'd0};
        3'd1:    c = '{kind: KIND_KITE, tip: TIP_PARENT, turn: 5'd16};
        3'd2:    c = '{kind: KIND_KITE, tip: TIP_PARENT, turn: 5'd4};
        3'd3:    c = '{kind: KIND_DART, tip: TIP_LEFT,   turn: 5'd8};
        3'd4:    c = '{kind: KIND_DART, tip: TIP_RIGHT,  turn: 5'd12};
        default: c = '{kind: KIND_KITE, tip: TIP_PARENT, turn: 5'd0};
      endcase
    end
    return c;
  endfunction

  // Rounds a Q2.30-scaled magnitude to nearest, ties away from zero, then signs it.
  function automatic logic signed [OffW-1:0] round_scaled(input logic [ProdW-1:0] p,
                                                          input logic neg);
    logic [ProdW:0]  s;
    logic [OffW-1:0] m;
    s = {1'b0, p} + (ProdW+1)'(64'd1 << 29);
    m = {1'b0, s[ProdW:30]};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [CoordW-1:0] sat32(input logic signed [CtrW-1:0] v);
    if (v > CtrW'(64'sh7FFFFFFF)) begin
      return 32'h7FFFFFFF;
    end else if (v < -CtrW'(64'sh80000000)) begin
      return 32'h80000000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

[src/pkd_seq.sv]
`default_nettype none

module pkd_seq (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             tile_type_i,
  input  wire logic signed [pkd_pkg::CoordW-1:0] tile_x_i,
  input  wire logic signed [pkd_pkg::CoordW-1:0] tile_y_i,
  input  wire logic [pkd_pkg::SideW-1:0]        tile_side_i,
  input  wire logic [pkd_pkg::AngW-1:0]         tile_angle_i,
  output pkd_pkg::pkd_child_t                   child_o
);

  logic                              active_q, active_d;
  pkd_pkg::pkd_kind_e                type_q;
  logic signed [pkd_pkg::CoordW-1:0] x_q, y_q;
  logic [pkd_pkg::SideW-1:0]         side_q;
  logic [pkd_pkg::AngW-1:0]          angle_q, angle_d;
  logic [pkd_pkg::KidW-1:0]          k_q, k_d;
  logic                              is_last;
  logic                              accept;
  pkd_pkg::pkd_kid_t                 kid;

  always_comb begin
    if (type_q == pkd_pkg::KIND_DART) begin
      is_last = (k_q == pkd_pkg::KidW'(pkd_pkg::DartKids - 1));
    end else begin
      is_last = (k_q == pkd_pkg::KidW'(pkd_pkg::KiteKids - 1));
    end
  end

  assign busy   = active_q && !is_last;
  assign accept = start && !busy;

  always_comb begin
    angle_d = tile_angle_i;
    if (tile_angle_i >= pkd_pkg::AngW'(pkd_pkg::AngMod)) begin
      angle_d = tile_angle_i - pkd_pkg::AngW'(pkd_pkg::AngMod);
    end
  end

  always_comb begin
    active_d = active_q;
    k_d      = k_q;
    if (accept) begin
      active_d = 1'b1;
      k_d      = '0;
    end else if (active_q) begin
      active_d = !is_last;
      k_d      = k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
      type_q   <= pkd_pkg::KIND_KITE;
    end else begin
      active_q <= active_d;
      k_q      <= k_d;
      if (accept) begin
        type_q <= pkd_pkg::pkd_kind_e'(tile_type_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= tile_x_i;
      y_q     <= tile_y_i;
      side_q  <= tile_side_i;
      angle_q <= angle_d;
    end
  end

  assign kid = pkd_pkg::kid_lookup(type_q, k_q);

  always_comb begin
    child_o.valid  = active_q;
    child_o.kind   = kid.kind;
    child_o.tip    = kid.tip;
    child_o.last   = is_last;
    child_o.x      = x_q;
    child_o.y      = y_q;
    child_o.side   = side_q;
    child_o.angle  = angle_q;
    child_o.cangle = pkd_pkg::add_mod20(angle_q, kid.turn);
  end

endmodule

`default_nettype wire

[src/pkd_scale.sv]
`default_nettype none

module pkd_scale (
  input  wire logic                          clk_i,
  input  wire logic [pkd_pkg::SideW-1:0]     len_i,
  input  wire logic [pkd_pkg::AngW-1:0]      idx_i,
  output logic [pkd_pkg::ProdW-1:0]          prod_o,
  output logic                               neg_o
);

  pkd_pkg::pkd_trig_t            trig;
  logic [pkd_pkg::ProdW-1:0]     prod_d;

  assign trig   = pkd_pkg::cos_lookup(idx_i);
  assign prod_d = pkd_pkg::ProdW'(len_i) * pkd_pkg::ProdW'(trig.mag);

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
    neg_o  <= trig.neg;
  end

endmodule

`default_nettype wire

[src/pkd_geom.sv]
`default_nettype none

module pkd_geom (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pkd_pkg::pkd_child_t          child_i,
  output logic                              valid_o,
  output logic                              child_type_o,
  output logic [pkd_pkg::CoordW-1:0]        child_x_o,
  output logic [pkd_pkg::CoordW-1:0]        child_y_o,
  output logic [pkd_pkg::SideW-1:0]         child_side_o,
  output logic [pkd_pkg::AngW-1:0]          child_angle_o,
  output logic [pkd_pkg::CoordW-1:0]        center_x_o,
  output logic [pkd_pkg::CoordW-1:0]        center_y_o,
  output logic                              last_child_o
);

  localparam int unsigned NProdW = pkd_pkg::SideW + 32;
  localparam int unsigned DW     = pkd_pkg::SideW + 30;

  // Stage valid bits.
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q;

  // Fields carried down the pipe.
  pkd_pkg::pkd_kind_e kind_a_q, kind_b_q, kind_c_q, kind_d_q, kind_e_q;
  logic last_a_q, last_b_q, last_c_q, last_d_q, last_e_q;
  logic [pkd_pkg::AngW-1:0] cang_a_q, cang_b_q, cang_c_q, cang_d_q, cang_e_q;
  logic signed [pkd_pkg::CoordW-1:0] x_a_q, y_a_q;
  logic signed [pkd_pkg::TipW-1:0] tx_b_q, ty_b_q, tx_c_q, ty_c_q;
  logic signed [pkd_pkg::TipW-1:0] tx_d_q, ty_d_q, tx_e_q, ty_e_q;
  logic [pkd_pkg::SideW-1:0] ns_b_q, ns_c_q, ns_d_q, ns_e_q;

  // Stage A: inverse golden ratio product and tip offset products.
  logic [NProdW-1:0]          nprod_a_q;
  logic [pkd_pkg::AngW-1:0]   tip_ang;
  logic [pkd_pkg::SideW-1:0]  tip_len;
  logic [pkd_pkg::ProdW-1:0]  tcos_p, tsin_p;
  logic                       tcos_n, tsin_n;

  always_comb begin
    tip_ang = child_i.angle;
    tip_len = child_i.side;
    unique case (child_i.tip)
      pkd_pkg::TIP_LEFT:   tip_ang = pkd_pkg::add_mod20(child_i.angle,
                                       pkd_pkg::AngW'(pkd_pkg::TipTurnLeft));
      pkd_pkg::TIP_RIGHT:  tip_ang = pkd_pkg::add_mod20(child_i.angle,
                                       pkd_pkg::AngW'(pkd_pkg::TipTurnRight));
      pkd_pkg::TIP_PARENT: tip_len = '0;
      default:             tip_len = '0;
    endcase
  end

  pkd_scale u_tip_cos (
    .clk_i  (clk_i),
    .len_i  (tip_len),
    .idx_i  (tip_ang),
    .prod_o (tcos_p),
    .neg_o  (tcos_n)
  );

  pkd_scale u_tip_sin (
    .clk_i  (clk_i),
    .len_i  (tip_len),
    .idx_i  (pkd_pkg::add_mod20(tip_ang, pkd_pkg::AngW'(pkd_pkg::QuarterTurn))),
    .prod_o (tsin_p),
    .neg_o  (tsin_n)
  );

  always_ff @(posedge clk_i) begin
    nprod_a_q <= NProdW'(child_i.side) * NProdW'(pkd_pkg::InvPhiQ32);
    kind_a_q  <= child_i.kind;
    last_a_q  <= child_i.last;
    cang_a_q  <= child_i.cangle;
    x_a_q     <= child_i.x;
    y_a_q     <= child_i.y;
  end

  // Stage B: child side rounding and child tip sums.
  logic [NProdW:0] nsum;
  assign nsum = {1'b0, nprod_a_q} + (NProdW+1)'(64'd1 << 31);

  always_ff @(posedge clk_i) begin
    ns_b_q   <= nsum[NProdW-1:32];
    tx_b_q   <= pkd_pkg::TipW'(x_a_q) + pkd_pkg::TipW'(pkd_pkg::round_scaled(tcos_p, tcos_n));
    ty_b_q   <= pkd_pkg::TipW'(y_a_q) + pkd_pkg::TipW'(pkd_pkg::round_scaled(tsin_p, tsin_n));
    kind_b_q <= kind_a_q;
    last_b_q <= last_a_q;
    cang_b_q <= cang_a_q;
  end

  // Stage C: axis length product.
  logic [DW-1:0] d_c_q;

  always_ff @(posedge clk_i) begin
    d_c_q    <= DW'(ns_b_q) * DW'(pkd_pkg::Cos36Q30);
    ns_c_q   <= ns_b_q;
    tx_c_q   <= tx_b_q;
    ty_c_q   <= ty_b_q;
    kind_c_q <= kind_b_q;
    last_c_q <= last_b_q;
    cang_c_q <= cang_b_q;
  end

  // Stage D: centre distance, three quarters for a kite and half for a dart.
  logic [DW+2:0]              kite_sum;
  logic [DW:0]                dart_sum;
  logic [pkd_pkg::SideW-1:0]  mid_d;
  logic [pkd_pkg::SideW-1:0]  mid_d_q;

  always_comb begin
    kite_sum = (DW+3)'(d_c_q) + ((DW+3)'(d_c_q) << 1) + (DW+3)'(64'd1 << 31);
    dart_sum = (DW+1)'(d_c_q) + (DW+1)'(64'd1 << 30);
    if (kind_c_q == pkd_pkg::KIND_DART) begin
      mid_d = dart_sum[31 +: pkd_pkg::SideW];
    end else begin
      mid_d = kite_sum[32 +: pkd_pkg::SideW];
    end
  end

  always_ff @(posedge clk_i) begin
    mid_d_q  <= mid_d;
    ns_d_q   <= ns_c_q;
    tx_d_q   <= tx_c_q;
    ty_d_q   <= ty_c_q;
    kind_d_q <= kind_c_q;
    last_d_q <= last_c_q;
    cang_d_q <= cang_c_q;
  end

  // Stage E: centre offset products along the child heading.
  logic [pkd_pkg::ProdW-1:0] ccos_p, csin_p;
  logic                      ccos_n, csin_n;

  pkd_scale u_ctr_cos (
    .clk_i  (clk_i),
    .len_i  (mid_d_q),
    .idx_i  (cang_d_q),
    .prod_o (ccos_p),
    .neg_o  (ccos_n)
  );

  pkd_scale u_ctr_sin (
    .clk_i  (clk_i),
    .len_i  (mid_d_q),
    .idx_i  (pkd_pkg::add_mod20(cang_d_q, pkd_pkg::AngW'(pkd_pkg::QuarterTurn))),
    .prod_o (csin_p),
    .neg_o  (csin_n)
  );

  always_ff @(posedge clk_i) begin
    ns_e_q   <= ns_d_q;
    tx_e_q   <= tx_d_q;
    ty_e_q   <= ty_d_q;
    kind_e_q <= kind_d_q;
    last_e_q <= last_d_q;
    cang_e_q <= cang_d_q;
  end

  // Stage F: centre sums and saturation into the output register.
  logic signed [pkd_pkg::CtrW-1:0] cx, cy;

  assign cx = pkd_pkg::CtrW'(tx_e_q) +
              pkd_pkg::CtrW'(pkd_pkg::round_scaled(ccos_p, ccos_n));
  assign cy = pkd_pkg::CtrW'(ty_e_q) +
              pkd_pkg::CtrW'(pkd_pkg::round_scaled(csin_p, csin_n));

  always_ff @(posedge clk_i) begin
    child_type_o  <= kind_e_q;
    child_x_o     <= pkd_pkg::sat32(pkd_pkg::CtrW'(tx_e_q));
    child_y_o     <= pkd_pkg::sat32(pkd_pkg::CtrW'(ty_e_q));
    child_side_o  <= ns_e_q;
    child_angle_o <= cang_e_q;
    center_x_o    <= pkd_pkg::sat32(cx);
    center_y_o    <= pkd_pkg::sat32(cy);
    last_child_o  <= last_e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      va_q <= child_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  assign valid_o = vf_q;

endmodule

`default_nettype wire

[src/penrose_kite_dart_deflation_core.sv]
// Penrose kite and dart deflation core.
// A parent tile is given on the tile_* ports and taken at a rising edge where
// start is high and busy is low. The core then issues one child per cycle into
// a six-stage arithmetic pipeline: six children for a kite, five for a dart.
// Each child leaves as one beat on the child_*, center_* and last_child_o
// ports, marked by valid_o for exactly one cycle; last_child_o flags the final
// beat of a parent. The receiver cannot hold beats off and needs none.
// The children of a parent follow on consecutive cycles. Busy drops in the
// cycle the last child is issued, so the next parent may be accepted while
// that child is issued and its children follow the previous ones with no gap;
// the core takes a new parent before the last one has left the pipeline.
// Every multiplication is followed directly by a register, in stages A, C and
// E, which sets the pipeline depth.
// Reset clears the issue counter and the pipeline valid bits; no beat is
// produced until a parent has been accepted.
`default_nettype none

module penrose_kite_dart_deflation_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              tile_type_i,
  input  wire logic signed [pkd_pkg::CoordW-1:0] tile_x_i,
  input  wire logic signed [pkd_pkg::CoordW-1:0] tile_y_i,
  input  wire logic [pkd_pkg::SideW-1:0]         tile_side_i,
  input  wire logic [pkd_pkg::AngW-1:0]          tile_angle_i,
  output logic                                   valid_o,
  output logic                                   child_type_o,
  output logic signed [pkd_pkg::CoordW-1:0]      child_x_o,
  output logic signed [pkd_pkg::CoordW-1:0]      child_y_o,
  output logic [pkd_pkg::SideW-1:0]              child_side_o,
  output logic [pkd_pkg::AngW-1:0]               child_angle_o,
  output logic signed [pkd_pkg::CoordW-1:0]      center_x_o,
  output logic signed [pkd_pkg::CoordW-1:0]      center_y_o,
  output logic                                   last_child_o
);

  pkd_pkg::pkd_child_t child;

  pkd_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .tile_type_i  (tile_type_i),
    .tile_x_i     (tile_x_i),
    .tile_y_i     (tile_y_i),
    .tile_side_i  (tile_side_i),
    .tile_angle_i (tile_angle_i),
    .child_o      (child)
  );

  pkd_geom u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .child_i       (child),
    .valid_o       (valid_o),
    .child_type_o  (child_type_o),
    .child_x_o     (child_x_o),
    .child_y_o     (child_y_o),
    .child_side_o  (child_side_o),
    .child_angle_o (child_angle_o),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .last_child_o  (last_child_o)
  );

endmodule

`default_nettype wire

[bench/penrose_kite_dart_deflation_core_test.sv]
`default_nettype none

module penrose_kite_dart_deflation_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pkd_pkg::*;

  localparam int NumRandom  = 430;
  localparam int IdleMax    = 17;
  localparam int TailCycles = 24;
  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;

  typedef struct packed {
    pkd_kind_e                kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SideW-1:0]         side;
    logic [AngW-1:0]          angle;
  } tile_t;

  typedef struct packed {
    pkd_kind_e                kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SideW-1:0]         side;
    logic [AngW-1:0]          angle;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic                     final_kid;
  } child_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     tile_type_i = 1'b0;
  logic signed [CoordW-1:0] tile_x_i = '0;
  logic signed [CoordW-1:0] tile_y_i = '0;
  logic [SideW-1:0]         tile_side_i = '0;
  logic [AngW-1:0]          tile_angle_i = '0;
  logic                     valid_o;
  logic                     child_type_o;
  logic signed [CoordW-1:0] child_x_o;
  logic signed [CoordW-1:0] child_y_o;
  logic [SideW-1:0]         child_side_o;
  logic [AngW-1:0]          child_angle_o;
  logic signed [CoordW-1:0] center_x_o;
  logic signed [CoordW-1:0] center_y_o;
  logic                     last_child_o;

  tile_t  tile_q[$];
  child_t child_q[$];
  tile_t  cur_tile;
  child_t want;
  int     gap_left = 0;
  int     tiles_total = 0;
  int     tiles_taken = 0;
  int     kites_taken = 0;
  int     beats_seen = 0;
  int     errors = 0;

  penrose_kite_dart_deflation_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .tile_type_i   (tile_type_i),
    .tile_x_i      (tile_x_i),
    .tile_y_i      (tile_y_i),
    .tile_side_i   (tile_side_i),
    .tile_angle_i  (tile_angle_i),
    .valid_o       (valid_o),
    .child_type_o  (child_type_o),
    .child_x_o     (child_x_o),
    .child_y_o     (child_y_o),
    .child_side_o  (child_side_o),
    .child_angle_o (child_angle_o),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .last_child_o  (last_child_o)
  );

  function automatic longint cos_q30(input int k);
    case (k)
      0:  return 1073741824;
      1:  return 1021189159;
      2:  return 868675383;
      3:  return 631129609;
      4:  return 331804471;
      5:  return 0;
      6:  return -331804471;
      7:  return -631129609;
      8:  return -868675383;
      9:  return -1021189159;
      10: return -1073741824;
      11: return -1021189159;
      12: return -868675383;
      13: return -631129609;
      14: return -331804471;
      15: return 0;
      16: return 331804471;
      17: return 631129609;
      18: return 868675383;
      default: return 1021189159;
    endcase
  endfunction

  // Length times a Q2.30 factor, rounded half away from zero.
  function automatic longint scaled(input longint unsigned len, input longint c);
    longint unsigned mag;
    longint unsigned p;
    mag = (c < 0) ? longint'(-c) : c;
    p = (len * mag + 64'd536870912) >> 30;
    return (c < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [CoordW-1:0] clamp32(input longint v);
    if (v > CoordMax) return 32'h7FFFFFFF;
    if (v < CoordMin) return 32'h80000000;
    return v[CoordW-1:0];
  endfunction

  task automatic deflate_tile(input tile_t t);
    int                a;
    int                n;
    int                k;
    int                turn;
    int                va;
    pkd_kind_e         kind;
    pkd_tip_e          tip;
    longint unsigned   side;
    longint unsigned   nside;
    longint unsigned   d;
    longint unsigned   mid_kite;
    longint unsigned   mid_dart;
    longint unsigned   m;
    longint            px;
    longint            py;
    longint            tx;
    longint            ty;
    child_t            c;
    side = 64'(t.side);
    px = longint'($signed(t.x));
    py = longint'($signed(t.y));
    a = t.angle % AngMod;
    nside = (side * 64'h9E3779B9 + 64'h80000000) >> 32;
    d = nside * 64'd868675383;
    mid_kite = (64'd3 * d + 64'h80000000) >> 32;
    mid_dart = (d + 64'h40000000) >> 31;
    n = (t.kind == KIND_DART) ? DartKids : KiteKids;
    for (k = 0; k < n; k++) begin
      if (t.kind == KIND_KITE) begin
        kind = (k < 2) ? KIND_DART : KIND_KITE;
        tip = (k < 2) ? TIP_PARENT : (k < 4) ? TIP_LEFT : TIP_RIGHT;
        case (k)
          0: turn = 18;
          1: turn = 2;
          2: turn = 6;
          3: turn = 10;
          4: turn = 14;
          default: turn = 10;
        endcase
      end else begin
        kind = (k < 3) ? KIND_KITE : KIND_DART;
        tip = (k < 3) ? TIP_PARENT : (k == 3) ? TIP_LEFT : TIP_RIGHT;
        case (k)
          0: turn = 0;
          1: turn = 16;
          2: turn = 4;
          3: turn = 8;
          default: turn = 12;
        endcase
      end
      tx = px;
      ty = py;
      if (tip != TIP_PARENT) begin
        va = (a + ((tip == TIP_LEFT) ? TipTurnLeft : TipTurnRight)) % AngMod;
        tx += scaled(side, cos_q30(va));
        ty += scaled(side, cos_q30((va + QuarterTurn) % AngMod));
      end
      m = (kind == KIND_DART) ? mid_dart : mid_kite;
      c.kind = kind;
      c.x = clamp32(tx);
      c.y = clamp32(ty);
      c.side = nside[SideW-1:0];
      c.angle = AngW'((a + turn) % AngMod);
      c.cx = clamp32(tx + scaled(m, cos_q30(c.angle)));
      c.cy = clamp32(ty + scaled(m, cos_q30((c.angle + QuarterTurn) % AngMod)));
      c.final_kid = (k == n - 1);
      child_q.push_back(c);
    end
  endtask

  task automatic add_tile(input pkd_kind_e kind, input logic [31:0] x, input logic [31:0] y,
                          input logic [SideW-1:0] side, input logic [AngW-1:0] angle);
    tile_t t;
    t.kind = kind;
    t.x = x;
    t.y = y;
    t.side = side;
    t.angle = angle;
    tile_q.push_back(t);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
      2: return 32'h7FFFFFFF - $urandom_range(0, 32'h01FFFFFF);
      default: return 32'h80000000 + $urandom_range(0, 32'h01FFFFFF);
    endcase
  endfunction

  function automatic logic [SideW-1:0] pick_side();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return SideW'($urandom_range(0, 24'h03FFFF));
      default: return SideW'($urandom);
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // A tile stays on the ports until its beat is taken, then the next one
  // follows after a drawn pause, or at once when the pause is zero.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        deflate_tile(cur_tile);
        tiles_taken++;
        if (cur_tile.kind == KIND_KITE) kites_taken++;
        gap_left = ((tiles_taken / 60) % 3 == 2) ? 0 : $urandom_range(0, IdleMax);
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (tile_q.size() > 0) begin
        cur_tile = tile_q.pop_front();
        tile_type_i <= cur_tile.kind;
        tile_x_i <= cur_tile.x;
        tile_y_i <= cur_tile.y;
        tile_side_i <= cur_tile.side;
        tile_angle_i <= cur_tile.angle;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      beats_seen++;
      if (child_q.size() == 0) begin
        $display("%0t ns: child beat with nothing expected, expected none, got x=%h y=%h",
                 $time, child_x_o, child_y_o);
        errors++;
      end else begin
        want = child_q.pop_front();
        compare_field("child_type", want.kind, child_type_o);
        compare_field("child_x", want.x, child_x_o);
        compare_field("child_y", want.y, child_y_o);
        compare_field("child_side", want.side, child_side_o);
        compare_field("child_angle", want.angle, child_angle_o);
        compare_field("center_x", want.cx, center_x_o);
        compare_field("center_y", want.cy, center_y_o);
        compare_field("last_child", want.final_kid, last_child_o);
      end
    end
  end

  initial begin
    int i;
    add_tile(KIND_KITE, 32'h0, 32'h0, 24'h0, 5'd0);
    add_tile(KIND_DART, 32'h7FFFFFFF, 32'h80000000, 24'h0, 5'd19);
    add_tile(KIND_KITE, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 5'd0);
    add_tile(KIND_DART, 32'h80000000, 32'h80000000, 24'hFFFFFF, 5'd10);
    add_tile(KIND_KITE, 32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF, 5'd5);
    add_tile(KIND_DART, 32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 5'd15);
    for (i = 20; i < 32; i++) begin
      add_tile(pkd_kind_e'(i % 2), pick_coord(), pick_coord(), pick_side(), 5'(i));
    end
    add_tile(KIND_KITE, 32'h00010000, 32'hFFFF0000, 24'h000001, 5'd3);
    add_tile(KIND_DART, 32'h0, 32'h0, 24'h010000, 5'd7);
    for (i = 0; i < NumRandom; i++) begin
      add_tile(pkd_kind_e'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_side(),
               ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31))
                                           : 5'($urandom_range(0, 19)));
    end
    tiles_total = tile_q.size();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (tiles_taken < tiles_total) @(posedge clk_i);
    while (child_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("Deflated %0d parent tiles (%0d kites, %0d darts) into %0d child beats.",
             tiles_taken, kites_taken, tiles_taken - kites_taken, beats_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d of %0d tiles taken.", tiles_taken, tiles_total);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
